// ----- src/jmoc_pkg.sv -----
// Shared types and constants for the JPEG marker overhead counter.
// No dependencies; every other file except jmoc_stream_if imports this package.
package jmoc_pkg;

    localparam int OUT_BITS  = 32;
    localparam int SUM_W_DEF = 32;
    localparam int LEN_BITS  = 16;

    localparam logic [7:0] BYTE_FF    = 8'hFF;
    localparam logic [7:0] BYTE_STUFF = 8'h00;
    localparam logic [7:0] CODE_SOI   = 8'hD8;
    localparam logic [7:0] CODE_EOI   = 8'hD9;

    localparam logic [LEN_BITS-1:0] MARKER_BYTES = 16'd2;
    localparam logic [LEN_BITS-1:0] MIN_LEN      = 16'd2;

    localparam logic [1:0] PH_SCAN   = 2'd0;
    localparam logic [1:0] PH_LEN_HI = 2'd1;
    localparam logic [1:0] PH_LEN_LO = 2'd2;
    localparam logic [1:0] PH_SKIP   = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [OUT_BITS-1:0] overhead_bytes;
        logic                ended_in_segment;
    } t_out_item;

    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_stage;

endpackage

// ----- src/jmoc_stream_if.sv -----
// Valid/ready request channel carrying one payload of a given type.
// Depends on nothing; payload types come from jmoc_pkg at instantiation.
interface jmoc_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- src/jmoc_in_reg.sv -----
// Input register: holds one accepted byte until the scanner takes it.
// Depends on jmoc_pkg.
module jmoc_in_reg
    import jmoc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_ready,
    input  logic     i_advance,
    output t_stage   o_stage
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     accept;

    assign o_ready = !r_valid || i_advance;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

endmodule

// ----- src/jmoc_scan_core.sv -----
// Marker scanner state and saturating overhead total; one byte per advance.
// Depends on jmoc_pkg.
module jmoc_scan_core
    import jmoc_pkg::*;
#(
    parameter int SUM_W = SUM_W_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  t_stage    i_stage,
    output t_out_item o_result
);

    logic [1:0]            r_phase;
    logic [1:0]            n_phase;
    logic                  r_prev_ff;
    logic                  n_prev_ff;
    logic [7:0]            r_len_hi;
    logic [7:0]            n_len_hi;
    logic [LEN_BITS-1:0]   r_skip;
    logic [LEN_BITS-1:0]   n_skip;
    logic [SUM_W-1:0]      r_total;
    logic [SUM_W-1:0]      n_total;

    logic [7:0]            data;
    logic [LEN_BITS-1:0]   len;
    logic [LEN_BITS-1:0]   skip_dec;
    logic                  add_en;
    logic [LEN_BITS-1:0]   add_val;
    logic [SUM_W:0]        sum;
    logic [SUM_W-1:0]      upd_total;
    logic [1:0]            upd_phase;
    logic [OUT_BITS-1:0]   clamped;

    assign data     = i_stage.item.data_byte;
    assign len      = {r_len_hi, data};
    assign skip_dec = (r_skip != '0) ? (r_skip - 1'b1) : r_skip;

    always_comb begin
        upd_phase = r_phase;
        n_prev_ff = r_prev_ff;
        n_len_hi  = r_len_hi;
        n_skip    = r_skip;
        add_en    = 1'b0;
        add_val   = '0;
        unique case (r_phase)
            PH_SCAN: begin
                if (r_prev_ff && data != BYTE_STUFF) begin
                    add_en    = 1'b1;
                    add_val   = MARKER_BYTES;
                    n_prev_ff = 1'b0;
                    if (data != CODE_SOI && data != CODE_EOI) begin
                        upd_phase = PH_LEN_HI;
                    end
                end else begin
                    n_prev_ff = (data == BYTE_FF);
                end
            end
            PH_LEN_HI: begin
                n_prev_ff = 1'b0;
                n_len_hi  = data;
                upd_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_prev_ff = 1'b0;
                add_en    = 1'b1;
                add_val   = len;
                if (len > MIN_LEN) begin
                    n_skip    = len - MIN_LEN;
                    upd_phase = PH_SKIP;
                end else begin
                    n_skip    = '0;
                    upd_phase = PH_SCAN;
                end
            end
            PH_SKIP: begin
                n_prev_ff = 1'b0;
                n_skip    = skip_dec;
                if (skip_dec == '0) begin
                    upd_phase = PH_SCAN;
                end
            end
            default: begin
                upd_phase = PH_SCAN;
            end
        endcase
    end

    // saturating add
    assign sum       = {1'b0, r_total} + (SUM_W + 1)'(add_val);
    assign upd_total = !add_en ? r_total : (sum[SUM_W] ? '1 : sum[SUM_W-1:0]);

    generate
        if (SUM_W > OUT_BITS) begin : g_clamp
            assign clamped = (|upd_total[SUM_W-1:OUT_BITS]) ? '1
                                                            : upd_total[OUT_BITS-1:0];
        end else begin : g_extend
            assign clamped = OUT_BITS'(upd_total);
        end
    endgenerate

    assign o_result.overhead_bytes   = clamped;
    assign o_result.ended_in_segment = (upd_phase != PH_SCAN);

    // clear everything after the last byte of a stream
    always_comb begin
        n_phase = upd_phase;
        n_total = upd_total;
        if (i_stage.item.last_byte) begin
            n_phase = PH_SCAN;
            n_total = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SCAN;
            r_prev_ff <= 1'b0;
            r_len_hi  <= '0;
            r_skip    <= '0;
            r_total   <= '0;
        end else if (i_advance) begin
            r_phase   <= n_phase;
            r_prev_ff <= i_stage.item.last_byte ? 1'b0 : n_prev_ff;
            r_len_hi  <= i_stage.item.last_byte ? 8'h00 : n_len_hi;
            r_skip    <= i_stage.item.last_byte ? '0 : n_skip;
            r_total   <= n_total;
        end
    end

`ifndef SYNTH
    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SKIP |-> r_skip != '0)
        else $error("skip phase with nothing left to skip");

    a_ff_only_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prev_ff |-> r_phase == PH_SCAN)
        else $error("pending 0xFF outside scan phase");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_stage.item.last_byte |=> r_total == '0 && r_phase == PH_SCAN)
        else $error("state not cleared after last byte");
`endif

endmodule

// ----- src/jmoc_out_reg.sv -----
// Result register: holds one finished result until the receiver takes it.
// Depends on jmoc_pkg.
module jmoc_out_reg
    import jmoc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_result,
    input  logic      i_ready,
    output logic      o_free,
    output logic      o_valid,
    output t_out_item o_item
);

    logic      r_valid;
    logic      n_valid;
    t_out_item r_item;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- src/jpeg_marker_overhead_counter.sv -----
// JPEG marker overhead counter, top level.
// Input channel i_in: one stream byte per request, last_byte flags the end
// of the stream. Output channel o_out: one result per stream, carrying the
// overhead byte total (saturating, clamped to 32 bits) and a flag that the
// stream stopped inside a length field or segment body.
// A byte goes into an input register and is scanned from there; if it is
// the last byte, its result is loaded into the result register when the
// scanner advances on it, and o_out.valid is driven from that register.
// Throughput is one byte per cycle while no last byte waits on a pending
// result; the scanner state update is the only loop.
// Reset clears the scanner, the total and both register stages; after the
// last byte the scanner clears itself for the next stream.
// When the receiver stalls with a result pending, non-final bytes keep
// flowing; only a further last byte waits in the input register, and then
// i_in.ready drops until the pending result is taken.
// Depends on jmoc_pkg, jmoc_stream_if, jmoc_in_reg, jmoc_scan_core and
// jmoc_out_reg.
module jpeg_marker_overhead_counter
    import jmoc_pkg::*;
#(
    parameter int SUM_W = SUM_W_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    jmoc_stream_if.sink    i_in,
    jmoc_stream_if.source  o_out
);

    t_stage    stage;
    t_out_item result;
    t_out_item out_item;
    logic      advance;
    logic      out_free;
    logic      in_ready;
    logic      out_valid;

    assign advance = stage.valid && (!stage.item.last_byte || out_free);

    jmoc_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_item    (i_in.payload),
        .o_ready   (in_ready),
        .i_advance (advance),
        .o_stage   (stage)
    );

    jmoc_scan_core #(
        .SUM_W (SUM_W)
    ) u_scan_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_stage   (stage),
        .o_result  (result)
    );

    jmoc_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && stage.item.last_byte),
        .i_result (result),
        .i_ready  (o_out.ready),
        .o_free   (out_free),
        .o_valid  (out_valid),
        .o_item   (out_item)
    );

    assign i_in.ready    = in_ready;
    assign o_out.valid   = out_valid;
    assign o_out.payload = out_item;

endmodule

// ----- tb/sv/jpeg_marker_overhead_counter_tb.sv -----
// Self-checking testbench for jpeg_marker_overhead_counter: directed and random JPEG-like
// byte streams, one overhead total predicted per stream and compared in arrival order.
// Depends on jmoc_pkg, jmoc_stream_if and the counter RTL.
module jpeg_marker_overhead_counter_tb;
    import jmoc_pkg::*;

    localparam int          TOTAL_W      = SUM_W_DEF;
    localparam logic [63:0] TOTAL_CAP    = (TOTAL_W >= 64) ? {64{1'b1}}
                                                           : ((64'd1 << TOTAL_W) - 64'd1);
    localparam int          STALL_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES = 8;

    logic i_clk;
    logic i_rst_n;

    jmoc_stream_if #(.t_payload(t_in_item))  req_if ();
    jmoc_stream_if #(.t_payload(t_out_item)) res_if ();

    jpeg_marker_overhead_counter #(
        .SUM_W(TOTAL_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    logic [1:0]          sc_phase;
    logic                sc_prev_ff;
    logic [7:0]          sc_len_hi;
    logic [LEN_BITS-1:0] sc_skip_left;
    logic [63:0]         sc_total;

    t_out_item  totals_due[$];
    logic [7:0] stream_q[$];

    int error_count     = 0;
    int bytes_sent      = 0;
    int streams_sent    = 0;
    int totals_checked  = 0;
    int segment_endings = 0;
    int idle_cycles     = 0;

    int          burst_left = 1;
    int          gap_due    = 0;
    bit          gaps_on    = 1'b0;
    logic [15:0] stall_mask = 16'h0000;
    logic [3:0]  stall_idx  = 4'd0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void clear_scanner();
        sc_phase     = PH_SCAN;
        sc_prev_ff   = 1'b0;
        sc_len_hi    = 8'h00;
        sc_skip_left = '0;
        sc_total     = 64'd0;
    endfunction

    function automatic void add_overhead(input logic [63:0] amount);
        if (amount > TOTAL_CAP - sc_total) begin
            sc_total = TOTAL_CAP;
        end else begin
            sc_total = sc_total + amount;
        end
    endfunction

    function automatic void append_byte(input logic [7:0] value);
        stream_q.insert(stream_q.size(), value);
    endfunction

    function automatic void tally_byte(input t_in_item req);
        logic [LEN_BITS-1:0] seg_len;
        t_out_item           res;
        case (sc_phase)
            PH_SCAN: begin
                if (sc_prev_ff && req.data_byte != BYTE_STUFF) begin
                    add_overhead(64'(MARKER_BYTES));
                    sc_prev_ff = 1'b0;
                    if (req.data_byte != CODE_SOI && req.data_byte != CODE_EOI) begin
                        sc_phase = PH_LEN_HI;
                    end
                end else begin
                    sc_prev_ff = (req.data_byte == BYTE_FF);
                end
            end
            PH_LEN_HI: begin
                sc_prev_ff = 1'b0;
                sc_len_hi  = req.data_byte;
                sc_phase   = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                seg_len    = {sc_len_hi, req.data_byte};
                sc_prev_ff = 1'b0;
                add_overhead(64'(seg_len));
                if (seg_len > MIN_LEN) begin
                    sc_skip_left = seg_len - MIN_LEN;
                    sc_phase     = PH_SKIP;
                end else begin
                    sc_skip_left = '0;
                    sc_phase     = PH_SCAN;
                end
            end
            default: begin
                sc_prev_ff = 1'b0;
                if (sc_skip_left != 0) begin
                    sc_skip_left = sc_skip_left - 1'b1;
                end
                if (sc_skip_left == 0) begin
                    sc_phase = PH_SCAN;
                end
            end
        endcase
        if (req.last_byte) begin
            res.overhead_bytes   = ((sc_total >> OUT_BITS) != 0) ? {OUT_BITS{1'b1}}
                                                                 : sc_total[OUT_BITS-1:0];
            res.ended_in_segment = (sc_phase != PH_SCAN);
            totals_due.insert(totals_due.size(), res);
            clear_scanner();
        end
    endfunction

    task automatic send_byte(input logic [7:0] data, input logic last);
        t_in_item req;
        req.data_byte = data;
        req.last_byte = last;
        if (gap_due > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap_due) @(posedge i_clk);
            gap_due = 0;
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= req;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        tally_byte(req);
        bytes_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_due    = gaps_on ? $urandom_range(1, 12) : 0;
        end
    endtask

    task automatic send_stream();
        foreach (stream_q[i]) begin
            send_byte(stream_q[i], i == stream_q.size() - 1);
        end
        streams_sent++;
    endtask

    task automatic set_idling(input bit gaps, input logic [15:0] mask);
        gaps_on    = gaps;
        stall_mask = (&mask) ? (mask & 16'hFFFE) : mask;
    endtask

    function automatic void build_wellformed_stream();
        int         n_segs;
        int         seg_len;
        logic [7:0] marker;
        logic [7:0] data;
        stream_q.delete();
        if ($urandom_range(0, 9) != 0) begin
            append_byte(BYTE_FF);
            append_byte(CODE_SOI);
        end
        n_segs = $urandom_range(0, 4);
        for (int s = 0; s < n_segs; s++) begin
            marker = ($urandom_range(0, 7) == 0) ? BYTE_FF : 8'($urandom_range(1, 254));
            append_byte(BYTE_FF);
            append_byte(marker);
            if (marker != CODE_SOI && marker != CODE_EOI) begin
                case ($urandom_range(0, 19))
                    0:       seg_len = $urandom_range(0, 2);
                    1:       seg_len = $urandom_range(256, 65535);
                    default: seg_len = $urandom_range(3, 40);
                endcase
                append_byte(8'(seg_len >> 8));
                append_byte(8'(seg_len));
                // end the stream inside a long segment rather than skip it all
                if (seg_len > 255) begin
                    repeat ($urandom_range(0, 5)) append_byte(8'($urandom));
                    return;
                end
                if (seg_len > 2) begin
                    repeat (seg_len - 2) append_byte(8'($urandom));
                end
            end
        end
        repeat ($urandom_range(0, 30)) begin
            data = ($urandom_range(0, 7) == 0) ? BYTE_FF : 8'($urandom);
            append_byte(data);
            if (data == BYTE_FF) begin
                append_byte(BYTE_STUFF);
            end
        end
        if ($urandom_range(0, 9) != 0) begin
            append_byte(BYTE_FF);
            append_byte(CODE_EOI);
        end
        if (stream_q.size() == 0) begin
            append_byte(8'($urandom));
        end
    endfunction

    function automatic void build_noise_stream();
        stream_q.delete();
        repeat ($urandom_range(1, 30)) begin
            append_byte(($urandom_range(0, 2) == 0) ? BYTE_FF : 8'($urandom));
        end
    endfunction

    task automatic run_random_streams(input int item_budget);
        int stop_at;
        int pick;
        stop_at = bytes_sent + item_budget;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                build_wellformed_stream();
            end else if (pick < 9) begin
                build_wellformed_stream();
                repeat ($urandom_range(0, stream_q.size() - 1)) void'(stream_q.pop_back());
            end else begin
                build_noise_stream();
            end
            send_stream();
        end
    endtask

    task automatic test_soi_eoi();
        stream_q = '{BYTE_FF, CODE_SOI, BYTE_FF, CODE_EOI};
        send_stream();
    endtask

    task automatic test_stuffing_and_trailing_ff();
        stream_q = '{BYTE_FF, BYTE_STUFF, BYTE_FF};
        send_stream();
    endtask

    task automatic test_fill_marker_short_length();
        stream_q = '{BYTE_FF, BYTE_FF, 8'h00, 8'h01, BYTE_FF, 8'hC0};
        send_stream();
    endtask

    task automatic test_segment_skip();
        stream_q = '{BYTE_FF, 8'hE0, 8'h00, 8'h04, 8'hAA, 8'hBB, 8'h55};
        send_stream();
    endtask

    task automatic test_long_length_cut_short();
        stream_q = '{BYTE_FF, 8'hC4, BYTE_FF, BYTE_FF, 8'h12};
        send_stream();
    endtask

    task automatic test_streams_free_flow();
        set_idling(1'b0, 16'h0000);
        run_random_streams(500);
    endtask

    task automatic test_streams_sender_gaps();
        set_idling(1'b1, 16'h0000);
        run_random_streams(450);
    endtask

    task automatic test_streams_receiver_stalls();
        set_idling(1'b0, 16'($urandom));
        run_random_streams(450);
    endtask

    task automatic test_streams_heavy_backpressure();
        set_idling(1'b1, 16'($urandom) | 16'hF0F0);
        run_random_streams(500);
    endtask

    always @(posedge i_clk) begin
        res_if.ready <= !stall_mask[stall_idx];
        stall_idx    <= stall_idx + 4'd1;
    end

    always @(posedge i_clk) begin
        t_out_item due;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (totals_due.size() == 0) begin
                $display("%0t: unexpected result: overhead_bytes %0d ended_in_segment %0b",
                         $time, res_if.payload.overhead_bytes,
                         res_if.payload.ended_in_segment);
                error_count++;
            end else begin
                due = totals_due.pop_front();
                totals_checked++;
                if (due.ended_in_segment) begin
                    segment_endings++;
                end
                if (res_if.payload.overhead_bytes !== due.overhead_bytes) begin
                    $display("%0t: overhead_bytes mismatch: expected %0d, actual %0d",
                             $time, due.overhead_bytes, res_if.payload.overhead_bytes);
                    error_count++;
                end
                if (res_if.payload.ended_in_segment !== due.ended_in_segment) begin
                    $display("%0t: ended_in_segment mismatch: expected %0b, actual %0b",
                             $time, due.ended_in_segment, res_if.payload.ended_in_segment);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        i_rst_n        <= 1'b0;
        clear_scanner();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_idling(1'b1, 16'h0421);
        test_soi_eoi();
        test_stuffing_and_trailing_ff();
        test_fill_marker_short_length();
        test_segment_skip();
        test_long_length_cut_short();

        test_streams_free_flow();
        test_streams_sender_gaps();
        test_streams_receiver_stalls();
        test_streams_heavy_backpressure();

        req_if.valid <= 1'b0;
        while (totals_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Streamed %0d bytes in %0d streams under varied gaps and stalls;",
                 bytes_sent, streams_sent);
        $display("checked %0d totals, %0d of them ending inside a segment.",
                 totals_checked, segment_endings);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
